>>> src/wfpd_pkg.sv
package wfpd_pkg;

   localparam int GAIN_W     = 16;
   localparam int SUM_W      = 32;
   localparam int PWM_W      = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] REG_TARGET_DISTANCE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_P          = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_I          = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_D          = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_BASE_DRIVE      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_DRIVE       = 3'd5;

   localparam logic [PWM_W-1:0] MAX_DRIVE_RESET = 8'hFF;

   typedef struct packed {
      logic             forward;
      logic [PWM_W-1:0] pwm;
   } wheel_cmd_type;

endpackage

>>> src/wall_follow_pid_drive.sv
// Wall-following PID drive controller.
// Request channel: req_valid / req_stall with req_distance_sample, one wall
// distance sample per request. A request is taken on a clock edge with
// req_valid high and req_stall low.
// Response channel: rsp_valid / rsp_stall with the direction and PWM of the
// left and right wheels, one response per request, in request order.
// Configuration: csr_wr_en / csr_index / csr_wdata write target distance,
// P/I/D gains (signed Q8.8), base drive and max drive. Write only while idle.
// Throughput: one request per cycle while rsp_stall is low, set by the
// four-stage pipeline (error/integral, multiply, accumulate/scale, wheel
// drive and clamp), whose stages advance while the next stage is free.
// When rsp_stall is high the response holds; the pipeline keeps filling its
// empty stages and raises req_stall only once all four stages are full.
// Reset (synchronous, active high) clears the integral, the previous error,
// the pipeline and the registers (max drive resets to 255, the rest to 0).
module wall_follow_pid_drive #(
   parameter int DISTANCE_BITS  = 12,
   parameter int GAIN_FRAC_BITS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [DISTANCE_BITS-1:0]            req_distance_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_left_forward,
   output logic [wfpd_pkg::PWM_W-1:0]          rsp_left_pwm,
   output logic                                rsp_right_forward,
   output logic [wfpd_pkg::PWM_W-1:0]          rsp_right_pwm,
   input  logic                                csr_wr_en,
   input  logic [wfpd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [wfpd_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int DW     = DISTANCE_BITS;
   localparam int GW     = wfpd_pkg::GAIN_W;
   localparam int SW     = wfpd_pkg::SUM_W;
   localparam int PW     = wfpd_pkg::PWM_W;
   localparam int E_W    = DW + 1;
   localparam int D_W    = DW + 2;
   localparam int PE_W   = GW + E_W;
   localparam int PI_W   = GW + SW;
   localparam int PD_W   = GW + D_W;
   localparam int ACC_W  = PI_W + 2;
   localparam int CORR_W = ACC_W - GAIN_FRAC_BITS;
   localparam int DRV_W  = CORR_W + 1;

   localparam logic signed [SW-1:0] SUM_MAX = {1'b0, {(SW-1){1'b1}}};
   localparam logic signed [SW-1:0] SUM_MIN = {1'b1, {(SW-1){1'b0}}};
   localparam logic [ACC_W-1:0] ROUND_BIAS =
      ACC_W'((64'd1 << GAIN_FRAC_BITS) - 64'd1);

   // configuration registers
   logic [DW-1:0]        target_ff;
   logic signed [GW-1:0] gain_p_ff, gain_i_ff, gain_d_ff;
   logic [PW-1:0]        base_drive_ff, max_drive_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff     <= '0;
         gain_p_ff     <= '0;
         gain_i_ff     <= '0;
         gain_d_ff     <= '0;
         base_drive_ff <= '0;
         max_drive_ff  <= wfpd_pkg::MAX_DRIVE_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            wfpd_pkg::REG_TARGET_DISTANCE: target_ff     <= csr_wdata[DW-1:0];
            wfpd_pkg::REG_GAIN_P:          gain_p_ff     <= csr_wdata[GW-1:0];
            wfpd_pkg::REG_GAIN_I:          gain_i_ff     <= csr_wdata[GW-1:0];
            wfpd_pkg::REG_GAIN_D:          gain_d_ff     <= csr_wdata[GW-1:0];
            wfpd_pkg::REG_BASE_DRIVE:      base_drive_ff <= csr_wdata[PW-1:0];
            wfpd_pkg::REG_MAX_DRIVE:       max_drive_ff  <= csr_wdata[PW-1:0];
            default: ;
         endcase
      end
   end

   // pipeline flow control
   logic s1_vld_ff, s2_vld_ff, s3_vld_ff, rsp_valid_ff;
   logic out_en, s3_en, s2_en, s1_en, req_take;

   assign out_en    = !rsp_valid_ff || !rsp_stall;
   assign s3_en     = !s3_vld_ff || out_en;
   assign s2_en     = !s2_vld_ff || s3_en;
   assign s1_en     = !s1_vld_ff || s2_en;
   assign req_stall = !s1_en;
   assign req_take  = req_valid && s1_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         s3_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_en)  s1_vld_ff    <= req_valid;
         if (s2_en)  s2_vld_ff    <= s1_vld_ff;
         if (s3_en)  s3_vld_ff    <= s2_vld_ff;
         if (out_en) rsp_valid_ff <= s3_vld_ff;
      end
   end

   // stage 1: error, saturating integral, derivative
   logic signed [SW-1:0]  error_sum_ff, sum_in;
   logic signed [E_W-1:0] last_error_ff, e_in;
   logic signed [SW:0]    sum_wide;
   logic signed [D_W-1:0] d_in;
   logic signed [E_W-1:0] e_ff;
   logic signed [SW-1:0]  sum_ff;
   logic signed [D_W-1:0] d_ff;

   assign e_in     = $signed({1'b0, req_distance_sample}) - $signed({1'b0, target_ff});
   assign sum_wide = (SW+1)'(error_sum_ff) + (SW+1)'(e_in);
   assign d_in     = D_W'(e_in) - D_W'(last_error_ff);

   always_comb begin
      if (sum_wide[SW] != sum_wide[SW-1]) begin
         sum_in = sum_wide[SW] ? SUM_MIN : SUM_MAX;
      end else begin
         sum_in = sum_wide[SW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         error_sum_ff  <= '0;
         last_error_ff <= '0;
      end else if (req_take) begin
         error_sum_ff  <= sum_in;
         last_error_ff <= e_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         e_ff   <= e_in;
         sum_ff <= sum_in;
         d_ff   <= d_in;
      end
   end

   // stage 2: gain products
   logic signed [PE_W-1:0] pe_in, pe_ff;
   logic signed [PI_W-1:0] pi_in, pi_ff;
   logic signed [PD_W-1:0] pd_in, pd_ff;

   assign pe_in = gain_p_ff * e_ff;
   assign pi_in = gain_i_ff * sum_ff;
   assign pd_in = gain_d_ff * d_ff;

   always_ff @(posedge clock) begin
      if (s2_en && s1_vld_ff) begin
         pe_ff <= pe_in;
         pi_ff <= pi_in;
         pd_ff <= pd_in;
      end
   end

   // stage 3: accumulate, scale with truncation toward zero
   logic signed [ACC_W-1:0]  acc_in, biased;
   logic signed [CORR_W-1:0] corr_in, corr_ff;

   assign acc_in  = ACC_W'(pe_ff) + ACC_W'(pi_ff) + ACC_W'(pd_ff);
   assign biased  = acc_in + (acc_in[ACC_W-1] ? $signed(ROUND_BIAS) : $signed(ACC_W'(0)));
   assign corr_in = CORR_W'(biased >>> GAIN_FRAC_BITS);

   always_ff @(posedge clock) begin
      if (s3_en && s2_vld_ff) begin
         corr_ff <= corr_in;
      end
   end

   // stage 4: wheel drive, direction and clamp
   logic signed [DRV_W-1:0] base_ext, drive_left, drive_right;
   wfpd_pkg::wheel_cmd_type left_in, right_in, left_ff, right_ff;

   assign base_ext    = DRV_W'($signed({1'b0, base_drive_ff}));
   assign drive_left  = base_ext + DRV_W'(corr_ff);
   assign drive_right = base_ext - DRV_W'(corr_ff);

   wfpd_wheel #(.DRV_W(DRV_W)) u_left (
      .drive     (drive_left),
      .max_drive (max_drive_ff),
      .cmd       (left_in)
   );

   wfpd_wheel #(.DRV_W(DRV_W)) u_right (
      .drive     (drive_right),
      .max_drive (max_drive_ff),
      .cmd       (right_in)
   );

   always_ff @(posedge clock) begin
      if (out_en && s3_vld_ff) begin
         left_ff  <= left_in;
         right_ff <= right_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_left_forward  = left_ff.forward;
   assign rsp_left_pwm      = left_ff.pwm;
   assign rsp_right_forward = right_ff.forward;
   assign rsp_right_pwm     = right_ff.pwm;

   // checks
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_vld_ff && s2_vld_ff && s3_vld_ff && rsp_valid_ff && rsp_stall)
      else $error("request stalled with a free pipeline stage");

   a_take_fills_s1: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> s1_vld_ff)
      else $error("accepted request lost at stage 1");

   a_pwm_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_left_pwm <= max_drive_ff && rsp_right_pwm <= max_drive_ff)
      else $error("wheel PWM above max drive");

   a_zero_base_opposed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && base_drive_ff == '0 |-> !(rsp_left_forward && rsp_right_forward))
      else $error("both wheels forward with zero base drive");

endmodule

>>> src/wfpd_wheel.sv
module wfpd_wheel #(
   parameter int DRV_W = 36
) (
   input  logic signed [DRV_W-1:0]          drive,
   input  logic [wfpd_pkg::PWM_W-1:0]       max_drive,
   output wfpd_pkg::wheel_cmd_type          cmd
);

   logic             neg;
   logic [DRV_W-1:0] mag;

   assign neg = drive[DRV_W-1];
   assign mag = neg ? DRV_W'(-drive) : DRV_W'(drive);

   always_comb begin
      cmd.forward = !neg && (drive != '0);
      if (mag > DRV_W'(max_drive)) begin
         cmd.pwm = max_drive;
      end else begin
         cmd.pwm = mag[wfpd_pkg::PWM_W-1:0];
      end
   end

endmodule

>>> test/wall_follow_pid_drive_tb.sv
`timescale 1ns / 100ps

module wall_follow_pid_drive_tb;

   localparam int DIST_W = 12;
   localparam int FRAC_BITS = 8;
   localparam longint SUM_HI = 64'sd2147483647;
   localparam longint SUM_LO = -64'sd2147483648;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int DRAIN_CYCLES = 8;
   localparam logic [wfpd_pkg::CSR_IDX_W-1:0] REG_SPARE_LO = wfpd_pkg::REG_MAX_DRIVE + 3'd1;
   localparam logic [wfpd_pkg::CSR_IDX_W-1:0] REG_SPARE_HI = wfpd_pkg::REG_MAX_DRIVE + 3'd2;

   typedef struct packed {
      wfpd_pkg::wheel_cmd_type left;
      wfpd_pkg::wheel_cmd_type right;
   } drive_pair_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [DIST_W-1:0] req_distance_sample = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_left_forward;
   logic [wfpd_pkg::PWM_W-1:0] rsp_left_pwm;
   logic rsp_right_forward;
   logic [wfpd_pkg::PWM_W-1:0] rsp_right_pwm;
   logic csr_wr_en = 1'b0;
   logic [wfpd_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [wfpd_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // controller state and registers as the testbench tracks them
   logic [DIST_W-1:0] tgt_distance = '0;
   logic signed [wfpd_pkg::GAIN_W-1:0] kp = '0;
   logic signed [wfpd_pkg::GAIN_W-1:0] ki = '0;
   logic signed [wfpd_pkg::GAIN_W-1:0] kd = '0;
   logic [wfpd_pkg::PWM_W-1:0] base_lvl = '0;
   logic [wfpd_pkg::PWM_W-1:0] max_lvl = wfpd_pkg::MAX_DRIVE_RESET;
   logic signed [wfpd_pkg::SUM_W-1:0] integ_sum = '0;
   logic signed [DIST_W:0] prev_error = '0;

   logic [DIST_W-1:0] sample_q[$];
   drive_pair_type drive_q[$];
   int send_idle_pct = 0;
   int stall_pct = 0;
   int mismatch_count = 0;
   int cycle_count = 0;

   wall_follow_pid_drive #(
      .DISTANCE_BITS(DIST_W),
      .GAIN_FRAC_BITS(FRAC_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_distance_sample(req_distance_sample),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_left_forward(rsp_left_forward),
      .rsp_left_pwm(rsp_left_pwm),
      .rsp_right_forward(rsp_right_forward),
      .rsp_right_pwm(rsp_right_pwm),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic wfpd_pkg::wheel_cmd_type wheel_cmd(longint drive);
      wfpd_pkg::wheel_cmd_type w;
      longint mag;
      w.forward = drive > 0;
      mag = (drive > 0) ? drive : -drive;
      if (mag > longint'(max_lvl)) mag = longint'(max_lvl);
      w.pwm = mag[wfpd_pkg::PWM_W-1:0];
      return w;
   endfunction

   task automatic predict_drive(logic [DIST_W-1:0] sample);
      longint err, total, deriv, acc, corr;
      drive_pair_type p;
      err = longint'(sample) - longint'(tgt_distance);
      total = longint'(integ_sum) + err;
      if (total > SUM_HI) total = SUM_HI;
      if (total < SUM_LO) total = SUM_LO;
      integ_sum = total[wfpd_pkg::SUM_W-1:0];
      deriv = err - longint'(prev_error);
      prev_error = err[DIST_W:0];
      acc = longint'(kp) * err + longint'(ki) * total + longint'(kd) * deriv;
      // scale truncates toward zero
      corr = (acc < 0) ? -((-acc) >>> FRAC_BITS) : (acc >>> FRAC_BITS);
      p.left = wheel_cmd(longint'(base_lvl) + corr);
      p.right = wheel_cmd(longint'(base_lvl) - corr);
      drive_q.push_back(p);
   endtask

   task automatic report_mismatch(string what, longint got, longint want);
      mismatch_count++;
      $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want,
               cycle_count);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) predict_drive(req_distance_sample);
         if (req_valid && req_stall) begin
            req_valid <= 1'b1;
         end else if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_distance_sample <= sample_q.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      drive_pair_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (drive_q.size() == 0) begin
               report_mismatch("response with none expected", rsp_left_pwm, 0);
            end else begin
               want = drive_q.pop_front();
               if (rsp_left_forward !== want.left.forward)
                  report_mismatch("left_forward", rsp_left_forward, want.left.forward);
               if (rsp_left_pwm !== want.left.pwm)
                  report_mismatch("left_pwm", rsp_left_pwm, want.left.pwm);
               if (rsp_right_forward !== want.right.forward)
                  report_mismatch("right_forward", rsp_right_forward, want.right.forward);
               if (rsp_right_pwm !== want.right.pwm)
                  report_mismatch("right_pwm", rsp_right_pwm, want.right.pwm);
            end
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[wall_follow_pid_drive] ERROR");
         $finish;
      end
   end

   task automatic csr_write(logic [wfpd_pkg::CSR_IDX_W-1:0] idx,
                            logic [wfpd_pkg::CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         wfpd_pkg::REG_TARGET_DISTANCE: tgt_distance = data[DIST_W-1:0];
         wfpd_pkg::REG_GAIN_P: kp = data;
         wfpd_pkg::REG_GAIN_I: ki = data;
         wfpd_pkg::REG_GAIN_D: kd = data;
         wfpd_pkg::REG_BASE_DRIVE: base_lvl = data[wfpd_pkg::PWM_W-1:0];
         wfpd_pkg::REG_MAX_DRIVE: max_lvl = data[wfpd_pkg::PWM_W-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (sample_q.size() != 0 || req_valid || drive_q.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic load_config(logic [15:0] tgt, logic [15:0] p, logic [15:0] i,
                              logic [15:0] d, logic [15:0] base, logic [15:0] max);
      csr_write(wfpd_pkg::REG_TARGET_DISTANCE, tgt);
      csr_write(wfpd_pkg::REG_GAIN_P, p);
      csr_write(wfpd_pkg::REG_GAIN_I, i);
      csr_write(wfpd_pkg::REG_GAIN_D, d);
      csr_write(wfpd_pkg::REG_BASE_DRIVE, base);
      csr_write(wfpd_pkg::REG_MAX_DRIVE, max);
   endtask

   function automatic logic [15:0] pick_gain(bit corners);
      if (corners) return $urandom_range(1) ? 16'h8000 : 16'h7FFF;
      if ($urandom_range(3) == 0) return 16'($urandom);
      return 16'(int'($urandom_range(128)) - 64);
   endfunction

   function automatic logic [DIST_W-1:0] next_sample();
      int v;
      case ($urandom_range(3))
         0: begin
            v = int'(tgt_distance) + int'($urandom_range(80)) - 40;
            if (v < 0) v = 0;
            if (v > 4095) v = 4095;
            return v[DIST_W-1:0];
         end
         1: return $urandom_range(1) ? {DIST_W{1'b1}} : {DIST_W{1'b0}};
         default: return DIST_W'($urandom);
      endcase
   endfunction

   initial begin
      int send_pcts[4];
      int stall_pcts[4];
      bit corners;
      send_pcts = '{0, 88, 0, 9};
      stall_pcts = '{0, 0, 88, 9};
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset configuration: every drive is zero
      send_idle_pct = 30;
      stall_pct = 30;
      sample_q = '{12'd0, 12'd4095, 12'd1234};
      wait_drained();

      // unit P gain; upper target bits and spare indexes must be ignored
      load_config(16'hF800, 16'd256, 16'd0, 16'd0, 16'd100, 16'hFFFF);
      csr_write(REG_SPARE_LO, 16'hFFFF);
      csr_write(REG_SPARE_HI, 16'h5A5A);
      sample_q = '{12'd2048, 12'd2148, 12'd2348, 12'd0, 12'd4095};
      wait_drained();

      // gain extremes with zero clamp
      load_config(16'd4095, 16'h8000, 16'h7FFF, 16'h7FFF, 16'd255, 16'd0);
      sample_q = '{12'd0, 12'd4095, 12'd0};
      wait_drained();

      // derivative only
      load_config(16'd0, 16'd0, 16'd0, 16'd256, 16'd128, 16'd200);
      sample_q = '{12'd0, 12'd4095, 12'd4095, 12'd0, 12'd1000};
      wait_drained();

      // negative correction rounds toward zero
      load_config(16'd255, 16'd1, 16'd0, 16'd0, 16'd0, 16'd255);
      sample_q = '{12'd0, 12'd511};
      wait_drained();

      for (int ph = 0; ph < 8; ph++) begin
         send_idle_pct = send_pcts[ph % 4];
         stall_pct = stall_pcts[ph % 4];
         corners = (ph == 2 || ph == 5);
         load_config(corners ? ($urandom_range(1) ? 16'hFFFF : 16'h0000) : 16'($urandom),
                     pick_gain(corners), pick_gain(corners), pick_gain(corners),
                     corners ? ($urandom_range(1) ? 16'hFF00 : 16'h00FF) : 16'($urandom),
                     corners ? ($urandom_range(1) ? 16'hFF00 : 16'h00FF) : 16'($urandom));
         repeat (106) sample_q.push_back(next_sample());
         wait_drained();
      end

      if (mismatch_count == 0) begin
         $display("[wall_follow_pid_drive] OK");
      end else begin
         $display("[wall_follow_pid_drive] ERROR");
      end
      $finish;
   end

endmodule
